[rtl/core/text_console_writer_unit_defines.svh]
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every clock outside reset.
`define TCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every clock outside reset.
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/tcw_pkg.sv]
package tcw_pkg;

	localparam int TCW_COLUMNS = 80;
	localparam int TCW_ROWS    = 25;

	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 40;

	localparam logic [7:0]  NEWLINE_CODE     = 8'd10;
	localparam logic [7:0]  BACKSPACE_CODE   = 8'd8;
	localparam logic [7:0]  BLANK_CODE       = 8'd32;
	localparam logic [15:0] CLEAR_CELL       = 16'h0F20;
	localparam logic [7:0]  TEXT_COLOR_RESET = 8'd15;
	localparam logic [7:0]  GLYPH_RESET      = 8'd179;

	localparam logic REG_TEXT_COLOR      = 1'b0;
	localparam logic REG_BACKSPACE_GLYPH = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUT,
		ST_READ,
		ST_READ_DATA,
		ST_BS_MARK,
		ST_BS_BLANK,
		ST_SCROLL,
		ST_SCROLL_TAIL,
		ST_BLANK,
		ST_DONE
	} tcw_state_t;

	typedef struct packed {
		logic [7:0] text_color;
		logic [7:0] backspace_glyph;
	} tcw_cfg_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic        did_scroll;
		logic [6:0]  cursor_column;
		logic [4:0]  cursor_line;
		logic [10:0] cursor_position;
	} tcw_result_t;

endpackage

[rtl/core/tcw_screen_ram.sv]
module tcw_screen_ram
	import tcw_pkg::*;
#(
	parameter int DEPTH = TCW_COLUMNS * TCW_ROWS,
	parameter int AW    = $clog2(TCW_COLUMNS * TCW_ROWS)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/tcw_ctrl.sv]
module tcw_ctrl
	import tcw_pkg::*;
#(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS,
	parameter int AW      = $clog2(TCW_COLUMNS * TCW_ROWS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_mode,
	input  logic [7:0]    in_char,
	input  logic [10:0]   in_addr,
	input  tcw_cfg_t      cfg,
	input  logic          out_free,
	output logic          res_valid,
	output tcw_result_t   res,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [15:0]   mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [15:0]   mem_rdata
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int LW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int PW    = (AW > 11) ? AW : 11;
	localparam int LXW   = (LW > 5) ? LW : 5;

	localparam logic [AW-1:0] CELL_LAST   = AW'(CELLS - 1);
	localparam logic [AW-1:0] ROW_STEP    = AW'(COLUMNS);
	localparam logic [AW-1:0] COPY_LAST   = AW'((ROWS - 1) * COLUMNS - 1);
	localparam logic [AW-1:0] BLANK_FIRST = AW'((ROWS - 2) * COLUMNS);
	localparam logic [LW-1:0] LINE_STATUS = LW'(ROWS - 1);
	localparam logic [LW-1:0] LINE_LAST   = LW'(ROWS - 2);
	localparam logic [CW:0]   COL_END     = (CW + 1)'(COLUMNS);

	tcw_state_t    state_q, state_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] base_q, base_d;
	logic [LW-1:0] line_q, line_d;
	logic [CW-1:0] col_q, col_d;
	logic          scrolled_q, scrolled_d;
	logic          pend_q, pend_d;
	logic [AW-1:0] pend_addr_q, pend_addr_d;
	logic [7:0]    char_q, char_d;
	logic [10:0]   addr_q, addr_d;
	logic [15:0]   cell_q, cell_d;

	logic          bump;
	logic [AW-1:0] cell_addr;
	logic [CW:0]   col_inc;
	logic [LW-1:0] line_inc;
	logic [PW-1:0] addr_ext;
	logic [PW-1:0] pos_ext;
	logic [LXW-1:0] line_ext;

	// Shared address unit: row base plus column, optionally one cell further.
	assign cell_addr = base_q + AW'(col_q) + AW'(bump);
	assign col_inc   = {1'b0, col_q} + 1'b1;
	assign line_inc  = line_q + 1'b1;
	assign addr_ext  = PW'(addr_q);
	assign pos_ext   = PW'(cell_addr);
	assign line_ext  = LXW'(line_q);

	assign res.cursor_position = pos_ext[10:0];
	assign res.cursor_line     = line_ext[4:0];
	assign res.cursor_column   = 7'(col_q);
	assign res.did_scroll      = scrolled_q;
	assign res.cell_value      = cell_q;

	always_comb begin
		state_d     = state_q;
		ptr_d       = ptr_q;
		base_d      = base_q;
		line_d      = line_q;
		col_d       = col_q;
		scrolled_d  = scrolled_q;
		pend_d      = pend_q;
		pend_addr_d = pend_addr_q;
		char_d      = char_q;
		addr_d      = addr_q;
		cell_d      = cell_q;
		bump        = 1'b0;
		in_ready    = 1'b0;
		res_valid   = 1'b0;
		mem_we      = 1'b0;
		mem_waddr   = cell_addr;
		mem_wdata   = {cfg.text_color, BLANK_CODE};
		mem_raddr   = ptr_q;

		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = CLEAR_CELL;
				ptr_d     = ptr_q + 1'b1;
				if (ptr_q == CELL_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					char_d     = in_char;
					addr_d     = in_addr;
					scrolled_d = 1'b0;
					cell_d     = '0;
					state_d    = in_mode ? ST_READ : ST_PUT;
				end
			end
			ST_READ: begin
				mem_raddr = addr_ext[AW-1:0];
				state_d   = ST_READ_DATA;
			end
			ST_READ_DATA: begin
				cell_d  = (addr_ext < PW'(CELLS)) ? mem_rdata : '0;
				state_d = ST_DONE;
			end
			ST_PUT: begin
				state_d = ST_DONE;
				case (char_q)
					NEWLINE_CODE: begin
						col_d  = '0;
						line_d = line_inc;
						base_d = base_q + ROW_STEP;
						if (line_inc == LINE_STATUS) begin
							ptr_d   = ROW_STEP;
							state_d = ST_SCROLL;
						end
					end
					BACKSPACE_CODE: begin
						if (col_q != '0) begin
							col_d   = col_q - 1'b1;
							state_d = ST_BS_MARK;
						end
					end
					default: begin
						mem_we    = 1'b1;
						mem_wdata = {cfg.text_color, char_q};
						if (col_inc == COL_END) begin
							col_d  = '0;
							line_d = line_inc;
							base_d = base_q + ROW_STEP;
							if (line_inc == LINE_STATUS) begin
								ptr_d   = ROW_STEP;
								state_d = ST_SCROLL;
							end
						end else begin
							col_d = col_inc[CW-1:0];
						end
					end
				endcase
			end
			ST_BS_MARK: begin
				mem_we    = 1'b1;
				mem_wdata = {cfg.text_color, cfg.backspace_glyph};
				state_d   = ST_BS_BLANK;
			end
			ST_BS_BLANK: begin
				bump    = 1'b1;
				mem_we  = 1'b1;
				state_d = ST_DONE;
			end
			ST_SCROLL: begin
				// read one row below, write the cell read last cycle one row up
				pend_d      = 1'b1;
				pend_addr_d = ptr_q - ROW_STEP;
				mem_we      = pend_q;
				mem_waddr   = pend_addr_q;
				mem_wdata   = mem_rdata;
				ptr_d       = ptr_q + 1'b1;
				if (ptr_q == COPY_LAST) begin
					state_d = ST_SCROLL_TAIL;
				end
			end
			ST_SCROLL_TAIL: begin
				mem_we    = 1'b1;
				mem_waddr = pend_addr_q;
				mem_wdata = mem_rdata;
				pend_d    = 1'b0;
				ptr_d     = BLANK_FIRST;
				state_d   = ST_BLANK;
			end
			ST_BLANK: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				ptr_d     = ptr_q + 1'b1;
				if (ptr_q == COPY_LAST) begin
					line_d     = LINE_LAST;
					base_d     = BLANK_FIRST;
					col_d      = '0;
					scrolled_d = 1'b1;
					state_d    = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					res_valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			base_q     <= '0;
			line_q     <= '0;
			col_q      <= '0;
			scrolled_q <= 1'b0;
			pend_q     <= 1'b0;
		end else begin
			ptr_q      <= ptr_d;
			base_q     <= base_d;
			line_q     <= line_d;
			col_q      <= col_d;
			scrolled_q <= scrolled_d;
			pend_q     <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_q <= pend_addr_d;
		char_q      <= char_d;
		addr_q      <= addr_d;
		cell_q      <= cell_d;
	end

endmodule

[rtl/core/text_console_writer_unit.sv]
// Character-cell console. Put items print a byte at the cursor (newline and
// backspace handled), read items return one stored attribute:character cell.
// After reset the block sweeps the screen store to blanks, one cell a cycle;
// items are held off meanwhile, while configuration writes are taken at once.
// A step that scrolls adds a row copy and a blank row: the single write port
// of the screen memory moves one cell per cycle. The result sits in an output
// register, so the next item is accepted while the last result is still waiting.
module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // char_code[7:0], read_address[18:8], zero fill
	input  logic                s_tuser,  // mode
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // cursor_position[10:0], cursor_line[15:11],
	                                      // cursor_column[22:16], did_scroll[23],
	                                      // cell_value[39:24]
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);

	tcw_cfg_t      cfg_q;
	tcw_result_t   res;
	logic          res_valid;
	logic          out_free;
	logic          m_tvalid_q;
	tcw_result_t   m_data_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.text_color      <= TEXT_COLOR_RESET;
			cfg_q.backspace_glyph <= GLYPH_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TEXT_COLOR:      cfg_q.text_color      <= cfg_data;
				REG_BACKSPACE_GLYPH: cfg_q.backspace_glyph <= cfg_data;
				default: ;
			endcase
		end
	end

	tcw_ctrl #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS),
		.AW     (AW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_mode  (s_tuser),
		.in_char  (s_tdata[7:0]),
		.in_addr  (s_tdata[18:8]),
		.cfg      (cfg_q),
		.out_free (out_free),
		.res_valid(res_valid),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	tcw_screen_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Output register: free when empty or being drained this cycle.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			m_data_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

endmodule

[rtl/core/tcw_checker.sv]
`include "text_console_writer_unit_defines.svh"

module tcw_checker
	import tcw_pkg::*;
#(
	parameter int COLUMNS = TCW_COLUMNS,
	parameter int ROWS    = TCW_ROWS
) (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	`TCW_ASSERT_NEXT(a_one_item_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready, "input accepted twice in a row")

	`TCW_ASSERT_SAME(a_cursor_above_status, clk, arst_n, m_tvalid, (m_tdata[15:11] <= 5'(ROWS - 2)) && (m_tdata[22:16] < 7'(COLUMNS - 1) || m_tdata[22:16] == 7'(COLUMNS - 1)), "cursor outside the text area")

	`TCW_ASSERT_SAME(a_scroll_cursor, clk, arst_n, m_tvalid && m_tdata[23], (m_tdata[22:16] == 7'd0) && (m_tdata[15:11] == 5'(ROWS - 2)), "scroll left the cursor off the last text row")

	`TCW_ASSERT_NEXT(a_result_held, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind text_console_writer_unit tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (.*);
